// ===== src/mt64_pkg.sv =====
// ----------------------------------------------------------------------------
// MT19937-64 package
// Shared constants, state encoding and the twist and tempering functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mt64_pkg;

  localparam int TABLE_WORDS   = 312;
  localparam int MIDDLE_OFFSET = 156;
  localparam int IDX_W         = $clog2(TABLE_WORDS);
  localparam int WORD_W        = 64;

  localparam logic [63:0] SEED_RESET  = 64'd5489;
  localparam logic [63:0] TWIST_CONST = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] HIGH_PART   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LOW_PART    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] TEMPER_M0   = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TEMPER_MB   = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TEMPER_MC   = 64'hFFF7_EEE0_0000_0000;

  // Seeding multiplier 6364136223846793005, split into 32-bit halves.
  localparam logic [31:0] SEED_MUL_HI = 32'h5851_F42D;
  localparam logic [31:0] SEED_MUL_LO = 32'h4C95_7F2D;

  localparam int SHIFT_U = 29;
  localparam int SHIFT_S = 17;
  localparam int SHIFT_T = 37;
  localparam int SHIFT_L = 43;

  typedef enum logic [2:0] {
    ST_FILL_INIT,
    ST_FILL_MUL,
    ST_FILL_ADD,
    ST_IDLE,
    ST_DRAW
  } mt64_state_t;

  typedef logic [IDX_W-1:0]  mt64_idx_t;
  typedef logic [WORD_W-1:0] mt64_word_t;

  // Regenerates one table entry from its own old value, the following entry
  // and the entry half a table away.
  function automatic mt64_word_t mt64_mix(input mt64_word_t hi_word,
                                          input mt64_word_t lo_word,
                                          input mt64_word_t far_word);
    mt64_word_t x;
    mt64_word_t y;
    x = (hi_word & HIGH_PART) | (lo_word & LOW_PART);
    y = far_word ^ (x >> 1);
    if (x[0]) begin
      y = y ^ TWIST_CONST;
    end
    return y;
  endfunction

  function automatic mt64_word_t mt64_temper(input mt64_word_t w);
    mt64_word_t x;
    x = w;
    x = x ^ ((x >> SHIFT_U) & TEMPER_M0);
    x = x ^ ((x << SHIFT_S) & TEMPER_MB);
    x = x ^ ((x << SHIFT_T) & TEMPER_MC);
    x = x ^ (x >> SHIFT_L);
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== src/mt64_draw_if.sv =====
// ----------------------------------------------------------------------------
// MT19937-64 draw request channel
// Valid/ready channel that carries one draw request token.
// ----------------------------------------------------------------------------
`default_nettype none

interface mt64_draw_if;
  logic       valid;
  logic       ready;
  logic [0:0] draw;

  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

`default_nettype wire

// ===== src/mt64_word_if.sv =====
// ----------------------------------------------------------------------------
// MT19937-64 result channel
// Valid/ready channel that carries one tempered 64-bit random word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mt64_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== src/mt64_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mt64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/mersenne_twister_64_generator_top.sv =====
// ----------------------------------------------------------------------------
// MT19937-64 pseudo-random word generator
// Holds the 312-word state table in RAM, twists one entry per request and
// returns the tempered word.
// ----------------------------------------------------------------------------
// A request is accepted in ST_IDLE; ST_DRAW twists its entry and, once the
//   output register is free, loads it with the tempered word. in_req.ready is
//   high only in ST_IDLE, so no new request is taken before that load.
// Reset and seed writes refill the table from the seed, in_req.ready low:
//   ST_FILL_INIT, then ST_FILL_MUL and ST_FILL_ADD per entry (split multiply).
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_64_generator_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  mt64_draw_if.sink         in_req,
  mt64_word_if.source       out_rsp,
  input  wire logic         cfg_we,
  input  wire logic [63:0]  cfg_wdata
);

  import mt64_pkg::*;

  // The twist is done lazily, one entry per request. Walking the entries in
  // order, entries below the current index already hold the new generation
  // and the rest still hold the old one, which is exactly what the full
  // in-place twist sees at each step. So request k rewrites entry k from the
  // old entry k, the stored entry k+1 and the stored entry k+156 (mod 312).
  //
  // Entry k's old value is the entry k+1 read by the previous request (for the
  // first request after a fill, the seed), so it is carried in cur_r and only
  // two reads are needed per request. The table is kept in two RAM copies that
  // are written together: one reads the following entry, one the far entry.

  localparam mt64_idx_t LAST_IDX = IDX_W'(TABLE_WORDS - 1);
  localparam mt64_idx_t MID_IDX  = IDX_W'(MIDDLE_OFFSET);

  mt64_state_t state_r, state_nxt;

  logic [63:0] seed_r, seed_nxt;
  mt64_idx_t   idx_r, idx_nxt;        // fill index, then draw index
  mt64_word_t  prev_r, prev_nxt;      // last entry written during the fill
  mt64_word_t  cur_r, cur_nxt;        // stored value of the entry at idx_r
  logic [63:0] p_ll_r, p_ll_nxt;      // partial products of the seeding multiply
  logic [31:0] p_lh_r, p_lh_nxt;
  logic [31:0] p_hl_r, p_hl_nxt;
  logic        out_valid_r, out_valid_nxt;
  mt64_word_t  out_word_r, out_word_nxt;

  // RAM ports.
  logic       ram_we;
  mt64_idx_t  ram_waddr;
  mt64_word_t ram_wdata;
  mt64_idx_t  next_addr;
  mt64_idx_t  far_addr;
  mt64_word_t next_word;
  mt64_word_t far_word;

  // Datapath.
  mt64_word_t fill_x;
  mt64_word_t fill_word;
  mt64_word_t twisted;
  logic       slot_free;

  mt64_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_WORDS)) u_ram_next (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (next_addr),
    .rdata (next_word)
  );

  mt64_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_WORDS)) u_ram_far (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (far_addr),
    .rdata (far_word)
  );

  // Read addresses depend only on the draw index, so they are stable while a
  // request waits in ST_DRAW and the registered read data stays valid.
  always_comb begin
    next_addr = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
    far_addr  = (idx_r < MID_IDX) ? idx_r + MID_IDX : idx_r - MID_IDX;
  end

  // Seeding step: t[i] = M * (p ^ (p >> 62)) + i, mod 2^64. The multiply is
  // split into a full low-by-low product and two low-half cross products,
  // registered before they are summed in the next cycle.
  always_comb begin
    fill_x    = prev_r ^ (prev_r >> 62);
    p_ll_nxt  = {32'd0, SEED_MUL_LO} * {32'd0, fill_x[31:0]};
    p_lh_nxt  = SEED_MUL_LO * fill_x[63:32];
    p_hl_nxt  = SEED_MUL_HI * fill_x[31:0];
    fill_word = p_ll_r + {p_lh_r + p_hl_r, 32'd0} + {{(64-IDX_W){1'b0}}, idx_r};
  end

  assign twisted   = mt64_mix(cur_r, next_word, far_word);
  assign slot_free = !out_valid_r || out_rsp.ready;

  assign in_req.ready      = (state_r == ST_IDLE);
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.random_word = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = fill_word;

    case (state_r)
      ST_FILL_INIT: begin
        // Entry zero is the seed itself.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_r;
        prev_nxt  = seed_r;
        cur_nxt   = seed_r;
        idx_nxt   = IDX_W'(1);
        state_nxt = ST_FILL_MUL;
      end
      ST_FILL_MUL: begin
        state_nxt = ST_FILL_ADD;
      end
      ST_FILL_ADD: begin
        ram_we   = 1'b1;
        prev_nxt = fill_word;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_FILL_MUL;
        end
      end
      ST_IDLE: begin
        // A request with a clear draw bit is taken and dropped.
        if (in_req.valid && in_req.draw[0]) begin
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        // Hold until the output register can take the word.
        if (slot_free) begin
          ram_we        = 1'b1;
          ram_wdata     = twisted;
          cur_nxt       = next_word;
          idx_nxt       = next_addr;
          out_word_nxt  = mt64_temper(twisted);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_FILL_INIT;
      end
    endcase

    // A seed write restarts the fill from the new seed.
    if (cfg_we) begin
      seed_nxt  = cfg_wdata;
      state_nxt = ST_FILL_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL_INIT;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    p_ll_r     <= p_ll_nxt;
    p_lh_r     <= p_lh_nxt;
    p_hl_r     <= p_hl_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire
